// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Clock clk, reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/drcp_pkg.sv =====
// ----------------------------------------------------------------------------
// drcp_pkg
// Types, codes and defaults for the reduced-cost shortest path block.
// ----------------------------------------------------------------------------
package drcp_pkg;

	localparam int MAX_NODES_DEF = 16;
	localparam int MAX_ARCS_DEF  = 64;

	localparam int CFG_W = 7;

	localparam logic REG_NODES = 1'b0;
	localparam logic REG_ARCS  = 1'b1;

	localparam logic [1:0] CMD_LOAD_POT = 2'd0;
	localparam logic [1:0] CMD_LOAD_ARC = 2'd1;
	localparam logic [1:0] CMD_RUN      = 2'd2;

	// datapath operations issued by the controller
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT    = 4'd1;
	localparam logic [OP_W-1:0] OP_SCAN      = 4'd2;
	localparam logic [OP_W-1:0] OP_SETTLE    = 4'd3;
	localparam logic [OP_W-1:0] OP_ARC_RD    = 4'd4;
	localparam logic [OP_W-1:0] OP_ARC_CHK   = 4'd5;
	localparam logic [OP_W-1:0] OP_ARC_P1    = 4'd6;
	localparam logic [OP_W-1:0] OP_ARC_P2    = 4'd7;
	localparam logic [OP_W-1:0] OP_ARC_UPD   = 4'd8;
	localparam logic [OP_W-1:0] OP_WALK_RD   = 4'd9;
	localparam logic [OP_W-1:0] OP_WALK_DAT  = 4'd10;
	localparam logic [OP_W-1:0] OP_EMIT_RD   = 4'd11;
	localparam logic [OP_W-1:0] OP_EMIT_LD   = 4'd12;
	localparam logic [OP_W-1:0] OP_NOPATH_LD = 4'd13;

	typedef struct packed {
		logic [1:0]         command;
		logic [5:0]         slot;
		logic [3:0]         node_a;
		logic [3:0]         node_b;
		logic signed [15:0] arc_cost;
		logic signed [23:0] potential;
	} in_t;

	typedef struct packed {
		logic [5:0]         path_slot;
		logic [3:0]         from_node;
		logic [3:0]         to_node;
		logic signed [31:0] distance;
		logic               no_path;
		logic               last;
	} out_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic found;
		logic arc_none;
		logic take;
		logic arc_last;
		logic nopath;
		logic walk_done;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/drcp_ram.sv =====
// ----------------------------------------------------------------------------
// drcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/core/drcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// drcp_ctrl
// Sequencer: steps the datapath through load, scan, relax, walk and emit.
// ----------------------------------------------------------------------------
module drcp_ctrl import drcp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic run_req,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN     = 4'd1;
	localparam logic [3:0] S_SETTLE   = 4'd2;
	localparam logic [3:0] S_ARC_RD   = 4'd3;
	localparam logic [3:0] S_ARC_CHK  = 4'd4;
	localparam logic [3:0] S_ARC_P1   = 4'd5;
	localparam logic [3:0] S_ARC_P2   = 4'd6;
	localparam logic [3:0] S_ARC_UPD  = 4'd7;
	localparam logic [3:0] S_WALK_CHK = 4'd8;
	localparam logic [3:0] S_WALK_RD  = 4'd9;
	localparam logic [3:0] S_WALK_DAT = 4'd10;
	localparam logic [3:0] S_EMIT_RD  = 4'd11;
	localparam logic [3:0] S_EMIT_LD  = 4'd12;
	localparam logic [3:0] S_NOPATH   = 4'd13;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NOP;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_ACCEPT;
					if (run_req) state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.op = OP_SCAN;
				if (sts.scan_last) state_d = S_SETTLE;
			end
			S_SETTLE: begin
				cmd.op = OP_SETTLE;
				if (sts.found) begin
					state_d = sts.arc_none ? S_SCAN : S_ARC_RD;
				end else begin
					state_d = sts.nopath ? S_NOPATH : S_WALK_CHK;
				end
			end
			S_ARC_RD: begin
				cmd.op  = OP_ARC_RD;
				state_d = S_ARC_CHK;
			end
			S_ARC_CHK: begin
				cmd.op = OP_ARC_CHK;
				if (sts.take) state_d = S_ARC_P1;
				else state_d = sts.arc_last ? S_SCAN : S_ARC_RD;
			end
			S_ARC_P1: begin
				cmd.op  = OP_ARC_P1;
				state_d = S_ARC_P2;
			end
			S_ARC_P2: begin
				cmd.op  = OP_ARC_P2;
				state_d = S_ARC_UPD;
			end
			S_ARC_UPD: begin
				cmd.op  = OP_ARC_UPD;
				state_d = sts.arc_last ? S_SCAN : S_ARC_RD;
			end
			S_WALK_CHK: begin
				state_d = sts.walk_done ? S_EMIT_RD : S_WALK_RD;
			end
			S_WALK_RD: begin
				cmd.op  = OP_WALK_RD;
				state_d = S_WALK_DAT;
			end
			S_WALK_DAT: begin
				cmd.op  = OP_WALK_DAT;
				state_d = S_WALK_CHK;
			end
			S_EMIT_RD: begin
				cmd.op  = OP_EMIT_RD;
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.op = OP_EMIT_LD;
				if (sts.out_free) state_d = sts.emit_last ? S_IDLE : S_EMIT_RD;
			end
			S_NOPATH: begin
				cmd.op = OP_NOPATH_LD;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/core/drcp_dp.sv =====
// ----------------------------------------------------------------------------
// drcp_dp
// Datapath: potentials, node tables, arc RAM, distance arithmetic, output reg.
// ----------------------------------------------------------------------------
module drcp_dp import drcp_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_ARCS  = MAX_ARCS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  in_t              in_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data
);
	localparam int NW  = $clog2(MAX_NODES);
	localparam int NW1 = $clog2(MAX_NODES + 1);
	localparam int AW  = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
	localparam int AW1 = $clog2(MAX_ARCS + 1);
	localparam int RW  = 2 * NW + 16;
	localparam int WW  = 26;

	logic [4:0]              cfg_nodes_q;
	logic [6:0]              cfg_arcs_q;
	logic [NW1-1:0]          n_now, n_q;
	logic [AW1-1:0]          m_now, m_q;
	logic [3:0]              a4_q, b4_q;
	logic [NW-1:0]           i_q, u_q, cur_q;
	logic                    found_q;
	logic signed [31:0]      best_q, du_q;
	logic [AW-1:0]           j_q, ej_q;
	logic [NW-1:0]           src_arc_q, dst_arc_q;
	logic signed [15:0]      cost_q;
	logic signed [WW-1:0]    w_q;
	logic [NW1-1:0]          len_q, len_m1;
	logic [MAX_NODES-1:0]    reached_q, settled_q;
	logic signed [31:0]      dist_q  [MAX_NODES];
	logic [AW-1:0]           pred_q  [MAX_NODES];
	logic [AW-1:0]           chain_q [MAX_NODES];
	logic signed [23:0]      pot_q   [MAX_NODES];
	out_t                    out_q;
	logic                    out_valid_q;

	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [RW-1:0]           ram_rdata;
	logic [NW-1:0]           ram_src, ram_dst;
	logic signed [15:0]      ram_cost;

	logic [NW-1:0]           dist_ra, pot_ra;
	logic signed [31:0]      dist_rd, alt;
	logic signed [23:0]      pot_rd;
	logic                    a_ok, b_ok, run_a_ok, better, upd, out_free;
	logic                    pot_wr, out_load;

	assign ram_src  = ram_rdata[RW-1 -: NW];
	assign ram_dst  = ram_rdata[16 +: NW];
	assign ram_cost = $signed(ram_rdata[15:0]);

	// register clamping
	always_comb begin
		if (cfg_nodes_q == 5'd0) n_now = NW1'(1);
		else if (32'(cfg_nodes_q) > MAX_NODES) n_now = NW1'(MAX_NODES);
		else n_now = NW1'(cfg_nodes_q);
		if (32'(cfg_arcs_q) > MAX_ARCS) m_now = AW1'(MAX_ARCS);
		else m_now = AW1'(cfg_arcs_q);
	end

	always_comb begin
		case (cmd.op)
			OP_SCAN:    dist_ra = i_q;
			OP_ARC_UPD: dist_ra = dst_arc_q;
			default:    dist_ra = ram_dst;
		endcase
		pot_ra = (cmd.op == OP_ARC_P1) ? src_arc_q : dst_arc_q;
		case (cmd.op)
			OP_WALK_RD: ram_raddr = pred_q[cur_q];
			OP_EMIT_RD: ram_raddr = chain_q[len_m1[NW-1:0]];
			default:    ram_raddr = j_q;
		endcase
	end

	assign dist_rd  = dist_q[dist_ra];
	assign pot_rd   = pot_q[pot_ra];
	assign alt      = du_q + 32'(w_q);
	assign len_m1   = len_q - NW1'(1);
	assign out_free = !out_valid_q || out_ready;
	assign out_load = ((cmd.op == OP_EMIT_LD) || (cmd.op == OP_NOPATH_LD)) && out_free;
	assign better   = reached_q[i_q] && !settled_q[i_q] && (!found_q || dist_rd < best_q);
	assign upd      = !reached_q[dst_arc_q] || (alt < dist_rd);
	assign a_ok     = 32'(a4_q) < 32'(n_q);
	assign b_ok     = 32'(b4_q) < 32'(n_q);
	assign run_a_ok = 32'(in_data.node_a) < 32'(n_now);
	assign pot_wr   = (cmd.op == OP_ACCEPT) && (in_data.command == CMD_LOAD_POT) &&
	                  (32'(in_data.node_a) < MAX_NODES);

	assign ram_we = (cmd.op == OP_ACCEPT) && (in_data.command == CMD_LOAD_ARC) &&
	                (32'(in_data.slot) < MAX_ARCS);
	assign ram_re = (cmd.op == OP_ARC_RD) || (cmd.op == OP_WALK_RD) || (cmd.op == OP_EMIT_RD);

	drcp_ram #(.WIDTH(RW), .DEPTH(MAX_ARCS)) u_arc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_data.slot)),
		.wdata ({NW'(in_data.node_a), NW'(in_data.node_b), in_data.arc_cost}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts.scan_last = (NW1'(i_q) == n_q - NW1'(1));
		sts.found     = found_q;
		sts.arc_none  = (m_q == AW1'(0));
		sts.take      = (ram_src == u_q) && (NW1'(ram_dst) < n_q) && !settled_q[ram_dst];
		sts.arc_last  = (AW1'(j_q) + AW1'(1)) >= m_q;
		sts.nopath    = !a_ok || !b_ok || (a4_q == b4_q) || !reached_q[NW'(b4_q)];
		sts.walk_done = (cur_q == NW'(a4_q)) || (len_q == NW1'(MAX_NODES));
		sts.emit_last = (len_q == NW1'(1));
		sts.out_free  = out_free;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_nodes_q <= 5'd16;
			cfg_arcs_q  <= 7'd0;
			out_valid_q <= 1'b0;
			reached_q   <= '0;
			settled_q   <= '0;
			found_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			len_q       <= '0;
			for (int k = 0; k < MAX_NODES; k++) pot_q[k] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NODES) cfg_nodes_q <= cfg_wdata[4:0];
				else cfg_arcs_q <= cfg_wdata;
			end
			if (pot_wr) pot_q[NW'(in_data.node_a)] <= in_data.potential;
			// a new beat loads as the old one leaves
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_ACCEPT: begin
					if (in_data.command == CMD_RUN) begin
						settled_q <= '0;
						found_q   <= 1'b0;
						i_q       <= '0;
						reached_q <= run_a_ok ?
							(MAX_NODES'(1) << in_data.node_a) : '0;
					end
				end
				OP_SCAN: begin
					if (better) found_q <= 1'b1;
					i_q <= i_q + NW'(1);
				end
				OP_SETTLE: begin
					found_q <= 1'b0;
					i_q     <= '0;
					j_q     <= '0;
					len_q   <= '0;
					if (found_q) settled_q[u_q] <= 1'b1;
				end
				OP_ARC_CHK: begin
					if (!sts.take) j_q <= j_q + AW'(1);
				end
				OP_ARC_UPD: begin
					if (upd) reached_q[dst_arc_q] <= 1'b1;
					j_q <= j_q + AW'(1);
				end
				OP_WALK_RD: len_q <= len_q + NW1'(1);
				OP_EMIT_LD: begin
					if (out_free) len_q <= len_m1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				if (in_data.command == CMD_RUN) begin
					a4_q <= in_data.node_a;
					b4_q <= in_data.node_b;
					n_q  <= n_now;
					m_q  <= m_now;
					if (run_a_ok) dist_q[NW'(in_data.node_a)] <= '0;
				end
			end
			OP_SCAN: begin
				if (better) begin
					best_q <= dist_rd;
					u_q    <= i_q;
				end
			end
			OP_SETTLE: begin
				du_q  <= best_q;
				cur_q <= NW'(b4_q);
			end
			OP_ARC_CHK: begin
				src_arc_q <= ram_src;
				dst_arc_q <= ram_dst;
				cost_q    <= ram_cost;
			end
			OP_ARC_P1: w_q <= WW'(cost_q) - WW'(pot_rd);
			OP_ARC_P2: w_q <= w_q + WW'(pot_rd);
			OP_ARC_UPD: begin
				if (upd) begin
					dist_q[dst_arc_q] <= alt;
					pred_q[dst_arc_q] <= j_q;
				end
			end
			OP_WALK_RD: chain_q[len_q[NW-1:0]] <= pred_q[cur_q];
			OP_WALK_DAT: cur_q <= ram_src;
			OP_EMIT_RD: ej_q <= chain_q[len_m1[NW-1:0]];
			OP_EMIT_LD: begin
				if (out_free) begin
					out_q.path_slot <= 6'(ej_q);
					out_q.from_node <= 4'(ram_src);
					out_q.to_node   <= 4'(ram_dst);
					out_q.distance  <= dist_rd;
					out_q.no_path   <= 1'b0;
					out_q.last      <= (len_q == NW1'(1));
				end
			end
			OP_NOPATH_LD: begin
				if (out_free) begin
					out_q.path_slot <= '0;
					out_q.from_node <= a4_q;
					out_q.to_node   <= b4_q;
					out_q.distance  <= '0;
					out_q.no_path   <= 1'b1;
					out_q.last      <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== rtl/core/dijkstra_reduced_cost_path_top.sv =====
// ----------------------------------------------------------------------------
// dijkstra_reduced_cost_path_top
// Reduced-cost shortest path engine over a small directed graph.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_ready/in_data): one beat per command. Load
//    potential and load arc leave the block idle. Run search takes the block
//    busy until its last result beat is loaded into the output register.
//  - out channel (out_valid/out_ready/out_data): one beat per path arc,
//    source to target, last flagged; or one no_path beat.
//  - cfg port: cfg_we/cfg_index/cfg_wdata, written in a single cycle, idle only.
// Run: for each settled node, a sequential scan over all n nodes, then a
//  read and check of each arc, relaxing each arc that leaves the settled
//  node; a final scan, then a walk and an emit step per path arc. The
//  sequential node scan and the single arc RAM read port set its length.
// Reset clears the sequencer, node potentials and configuration (16 nodes,
//  0 arcs); the arc RAM is not cleared. If the receiver stalls, the last
//  loaded beat waits in the output register and the emit sequence pauses;
//  loads are taken meanwhile once the run has finished.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dijkstra_reduced_cost_path_top import drcp_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_ARCS  = MAX_ARCS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);
	cmd_t cmd;   // sequencer -> datapath operation
	sts_t sts;   // datapath -> sequencer status
	logic run_req;

	assign run_req = (in_data.command == CMD_RUN);

	drcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.run_req  (run_req),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	drcp_dp #(.MAX_NODES(MAX_NODES), .MAX_ARCS(MAX_ARCS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a run beat makes the block busy in the following cycle
	`ASSERT_NEXT(a_run_busy, in_valid && in_ready && in_data.command == CMD_RUN, !in_ready)
	// a no-path beat is always the only and final beat
	`ASSERT_IMPLY(a_nopath_last, out_valid && out_data.no_path, out_data.last)
	// a no-path beat carries zero slot and distance
	`ASSERT_IMPLY(a_nopath_zero, out_valid && out_data.no_path,
		out_data.path_slot == 6'd0 && out_data.distance == 32'sd0)

endmodule
